@@ rtl/aliq_pkg.sv @@
`timescale 1ns / 1ps

package aliq_pkg;

  localparam int NUMBER_WIDTH_DEF = 24;
  localparam int SUM_OUT_W        = 26;

  typedef enum logic [2:0] {
    S_IDLE,
    S_LOAD,
    S_START,
    S_WAIT,
    S_DONE
  } seq_state_e;

  // status from the shared divider back to the sequencer
  typedef struct packed {
    logic done;
    logic rem_zero;
  } div_rsp_t;

endpackage

@@ rtl/aliq_div.sv @@
`timescale 1ns / 1ps

// Restoring divider, one quotient bit per cycle.
module aliq_div import aliq_pkg::*; #(
  parameter int NumW = NUMBER_WIDTH_DEF,
  parameter int DivW = (NUMBER_WIDTH_DEF + 1) / 2 + 1
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            start_i,
  input  logic [NumW-1:0] dividend_i,
  input  logic [DivW-1:0] divisor_i,
  output logic [NumW-1:0] quot_o,
  output div_rsp_t        rsp_o
);

  localparam int CntW = $clog2(NumW);

  logic            run_q, run_d;
  logic            done_q, done_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic [DivW-1:0] rem_q, rem_d;
  logic [DivW-1:0] dvs_q, dvs_d;
  logic [NumW-1:0] quo_q, quo_d;

  logic [DivW:0]   trial;
  logic [DivW:0]   diff;
  logic            ge;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q  <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      run_q  <= run_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    dvs_q <= dvs_d;
    quo_q <= quo_d;
  end

  always_comb begin
    // dividend bits shift out of the top of quo_q while quotient bits shift in
    trial  = {rem_q, quo_q[NumW-1]};
    diff   = trial - {1'b0, dvs_q};
    ge     = (trial >= {1'b0, dvs_q});
    run_d  = run_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    rem_d  = rem_q;
    dvs_d  = dvs_q;
    quo_d  = quo_q;
    if (start_i) begin
      run_d = 1'b1;
      cnt_d = '0;
      rem_d = '0;
      dvs_d = divisor_i;
      quo_d = dividend_i;
    end else if (run_q) begin
      rem_d = ge ? diff[DivW-1:0] : trial[DivW-1:0];
      quo_d = {quo_q[NumW-2:0], ge};
      cnt_d = cnt_q + 1'b1;
      if (cnt_q == CntW'(NumW - 1)) begin
        run_d  = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  assign quot_o         = quo_q;
  assign rsp_o.done     = done_q;
  assign rsp_o.rem_zero = (rem_q == '0);

endmodule

@@ rtl/aliquot_sum_amicable_check_core.sv @@
`timescale 1ns / 1ps
// One shared restoring divider sets the timing: each trial divisor takes a launch, the
// shift steps of the divider and a check of its quotient and remainder.
// Throughput: one item at a time; busy_o stays high through the result strobe cycle.
// valid_o marks the result on the outputs for one cycle; the receiver cannot stall.
// Reset (async, active low) returns the sequencer to idle; no item is held.
module aliquot_sum_amicable_check_core import aliq_pkg::*; #(
  parameter int NumberWidth = NUMBER_WIDTH_DEF
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   start_i,
  output logic                   busy_o,
  input  logic [NumberWidth-1:0] first_number_i,
  input  logic [NumberWidth-1:0] second_number_i,
  output logic                   valid_o,
  output logic                   is_amicable_o,
  output logic [SUM_OUT_W-1:0]   first_divisor_sum_o,
  output logic [SUM_OUT_W-1:0]   second_divisor_sum_o
);

  localparam int DivW = (NumberWidth + 1) / 2 + 1;
  localparam int SumW = NumberWidth + 3;

  seq_state_e state_q, state_d;
  logic       phase_q, phase_d;

  logic [NumberWidth-1:0] a_q, a_d, b_q, b_d, n_q, n_d;
  logic [DivW-1:0]        d_q, d_d;
  logic [SumW-1:0]        acc_q, acc_d, sum_a_q, sum_a_d, sum_b_q, sum_b_d;

  logic                   div_start;
  logic [NumberWidth-1:0] quot;
  div_rsp_t               div_rsp;
  logic [NumberWidth-1:0] d_ext;
  logic                   more;
  logic [NumberWidth-1:0] n_sel;

  aliq_div #(
    .NumW (NumberWidth),
    .DivW (DivW)
  ) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (n_q),
    .divisor_i  (d_q),
    .quot_o     (quot),
    .rsp_o      (div_rsp)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      phase_q <= 1'b0;
    end else begin
      state_q <= state_d;
      phase_q <= phase_d;
    end
  end

  always_ff @(posedge clk_i) begin
    a_q     <= a_d;
    b_q     <= b_d;
    n_q     <= n_d;
    d_q     <= d_d;
    acc_q   <= acc_d;
    sum_a_q <= sum_a_d;
    sum_b_q <= sum_b_d;
  end

  always_comb begin
    d_ext = NumberWidth'(d_q);
    // d*d <= n exactly when n/d >= d
    more  = (quot >= d_ext);
    n_sel = phase_q ? b_q : a_q;

    state_d   = state_q;
    phase_d   = phase_q;
    a_d       = a_q;
    b_d       = b_q;
    n_d       = n_q;
    d_d       = d_q;
    acc_d     = acc_q;
    sum_a_d   = sum_a_q;
    sum_b_d   = sum_b_q;
    div_start = 1'b0;

    unique case (state_q)
      S_IDLE: begin
        if (start_i) begin
          a_d     = first_number_i;
          b_d     = second_number_i;
          phase_d = 1'b0;
          state_d = S_LOAD;
        end
      end
      S_LOAD: begin
        n_d     = n_sel;
        d_d     = DivW'(2);
        // 1 always divides n >= 2; n of 0 or 1 sums to 0
        acc_d   = (n_sel >= NumberWidth'(2)) ? SumW'(1) : '0;
        state_d = S_START;
      end
      S_START: begin
        div_start = 1'b1;
        state_d   = S_WAIT;
      end
      S_WAIT: begin
        if (div_rsp.done) begin
          if (more) begin
            if (div_rsp.rem_zero) begin
              acc_d = acc_q + SumW'(d_q) + ((quot != d_ext) ? SumW'(quot) : '0);
            end
            d_d     = d_q + 1'b1;
            state_d = S_START;
          end else if (!phase_q) begin
            sum_a_d = acc_q;
            phase_d = 1'b1;
            state_d = S_LOAD;
          end else begin
            sum_b_d = acc_q;
            state_d = S_DONE;
          end
        end
      end
      S_DONE: begin
        state_d = S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  assign busy_o               = (state_q != S_IDLE);
  assign valid_o              = (state_q == S_DONE);
  assign is_amicable_o        = (sum_a_q == SumW'(b_q)) && (sum_b_q == SumW'(a_q))
                                && (a_q != b_q);
  assign first_divisor_sum_o  = SUM_OUT_W'(sum_a_q);
  assign second_divisor_sum_o = SUM_OUT_W'(sum_b_q);

  // result strobe lasts exactly one cycle
  assert property (@(posedge clk_i) disable iff (!rst_ni) valid_o |=> !valid_o)
    else $error("result strobe longer than one cycle");

  // an accepted item makes the block busy next cycle
  assert property (@(posedge clk_i) disable iff (!rst_ni) (start_i && !busy_o) |=> busy_o)
    else $error("item accepted but block not busy");

  // divider only reports back while the sequencer waits on it
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_rsp.done |-> (state_q == S_WAIT))
    else $error("divider done outside wait state");

  // a divider launch is followed by the wait state
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_start |=> (state_q == S_WAIT))
    else $error("divider launch not followed by wait");

  // an amicable pair never has equal members
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_o && is_amicable_o) |-> (first_divisor_sum_o != second_divisor_sum_o
      || sum_a_q != sum_b_q))
    else $error("amicable flag set on equal numbers");

endmodule
